/* src/afk_pkg.sv */
// ----------------------------------------------------------------------------
// afk_pkg - shared types and constants for the arm forward kinematics block
// Holds the CORDIC arctangent table, gain, position limit and config indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package afk_pkg;

    localparam int TABLE_LEN = 24;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [18:0] POS_LIMIT = 19'sd262143;

    localparam logic CFG_UPPER = 1'b0;
    localparam logic CFG_LOWER = 1'b1;

    // sine and cosine of one joint, Q1.15
    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] c;
    } sincos_t;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] r;
        case (idx)
            5'd0: r = 32'sd268435456;
            5'd1: r = 32'sd158466703;
            5'd2: r = 32'sd83729454;
            5'd3: r = 32'sd42502378;
            5'd4: r = 32'sd21333666;
            5'd5: r = 32'sd10677233;
            5'd6: r = 32'sd5339919;
            5'd7: r = 32'sd2670123;
            5'd8: r = 32'sd1335082;
            5'd9: r = 32'sd667543;
            5'd10: r = 32'sd333772;
            5'd11: r = 32'sd166886;
            5'd12: r = 32'sd83443;
            5'd13: r = 32'sd41722;
            5'd14: r = 32'sd20861;
            5'd15: r = 32'sd10430;
            5'd16: r = 32'sd5215;
            5'd17: r = 32'sd2608;
            5'd18: r = 32'sd1304;
            5'd19: r = 32'sd652;
            5'd20: r = 32'sd326;
            5'd21: r = 32'sd163;
            5'd22: r = 32'sd81;
            5'd23: r = 32'sd41;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/afk_cordic.sv */
// ----------------------------------------------------------------------------
// afk_cordic - pipelined CORDIC sine/cosine lane
// One rotation stage per cycle while en is high; the folded input, each rotation stage and the output are registered.
// ----------------------------------------------------------------------------
`default_nettype none
module afk_cordic
    import afk_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire               clk,
    input  wire               en,
    input  wire signed [15:0] angle,
    output sincos_t           result
);

    localparam int NS = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;

    logic signed [33:0] x_reg [0:NS];
    logic signed [33:0] y_reg [0:NS];
    logic signed [31:0] z_reg [0:NS];
    logic               neg_reg [0:NS];
    sincos_t            out_reg;

    logic signed [16:0] a_fold;
    logic               neg_next;

    // fold into [-pi/2, pi/2]
    always_comb
    begin
        a_fold   = 17'(angle);
        neg_next = 1'b0;
        if (angle > 16'sd16384)
        begin
            a_fold   = 17'(angle) - 17'sd32768;
            neg_next = 1'b1;
        end
        else if (angle < -16'sd16384)
        begin
            a_fold   = 17'(angle) + 17'sd32768;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= 34'(CORDIC_GAIN_Q30);
            y_reg[0]   <= '0;
            z_reg[0]   <= 32'(a_fold) <<< 15;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(5'(i));
                end
            end
        end
    end

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v,
                                                 input logic neg);
        logic signed [33:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (neg)
            r = -r;
        if (r > 34'sd32767)
            r = 34'sd32767;
        if (r < -34'sd32768)
            r = -34'sd32768;
        return r[15:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.s <= to_q15(y_reg[NS], neg_reg[NS]);
            out_reg.c <= to_q15(x_reg[NS], neg_reg[NS]);
        end
    end

    assign result = out_reg;

endmodule
`default_nettype wire

/* src/afk_merge.sv */
// ----------------------------------------------------------------------------
// afk_merge - combines the four lanes into x, y, z
// Four register stages: pair products, bracket terms, link scaling, round.
// ----------------------------------------------------------------------------
`default_nettype none
module afk_merge
    import afk_pkg::*;
(
    input  wire               clk,
    input  wire               en,
    input  sincos_t           j0,
    input  sincos_t           j1,
    input  sincos_t           j2,
    input  sincos_t           j3,
    input  wire        [15:0] upper_len,
    input  wire        [15:0] lower_len,
    output logic signed [18:0] x_pos,
    output logic signed [18:0] y_pos,
    output logic signed [18:0] z_pos,
    output logic               sat
);

    // stage 1: two-factor products (Q30) and passthrough factors
    logic signed [31:0] c0c1_reg, c1s0_reg, c2c3_reg, c0c3_reg, s1s2_reg;
    logic signed [31:0] s1s3_reg, c1c3_reg, c3s0_reg, s1k_reg;
    logic signed [15:0] c0_1_reg, s0_1_reg, s2_1_reg, s3_1_reg, c1_1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0c1_reg <= j0.c * j1.c;
            c1s0_reg <= j1.c * j0.s;
            c2c3_reg <= j2.c * j3.c;
            c0c3_reg <= j0.c * j3.c;
            s1s2_reg <= j1.s * j2.s;
            s1s3_reg <= j1.s * j3.s;
            c1c3_reg <= j1.c * j3.c;
            c3s0_reg <= j3.c * j0.s;
            s1k_reg  <= 32'(j1.s) <<< 15;
            c0_1_reg <= j0.c;
            s0_1_reg <= j0.s;
            s2_1_reg <= j2.s;
            s3_1_reg <= j3.s;
            c1_1_reg <= j1.c;
        end
    end

    // stage 2: bracket terms, then exact Q60 sum rounded to Q30
    logic signed [47:0] t_c0c1s3, t_c2c3s0, t_c0c2c3, t_c1s0s3, t_c1c3s2;
    logic signed [63:0] t_c0c3s1s2, t_c3s0s1s2;
    logic signed [63:0] bx, by, bz;
    logic signed [33:0] bx_reg, by_reg, bz_reg;
    logic signed [31:0] ax_reg, ay_reg, az_reg;

    always_comb
    begin
        t_c0c1s3   = c0c1_reg * s3_1_reg;
        t_c2c3s0   = c2c3_reg * s0_1_reg;
        t_c1s0s3   = c1s0_reg * s3_1_reg;
        t_c1c3s2   = c1c3_reg * s2_1_reg;
        t_c0c3s1s2 = c0c3_reg * s1s2_reg;
        t_c3s0s1s2 = c3s0_reg * s1s2_reg;
        t_c0c2c3   = c2c3_reg * c0_1_reg;
        bx = -(64'(t_c0c1s3) <<< 15) - (64'(t_c2c3s0) <<< 15) + t_c0c3s1s2;
        by = (64'(t_c0c2c3) <<< 15) - (64'(t_c1s0s3) <<< 15) + t_c3s0s1s2;
        bz = -(64'(s1s3_reg) <<< 30) - (64'(t_c1c3s2) <<< 15);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bx_reg <= 34'((bx + 64'sd536870912) >>> 30);
            by_reg <= 34'((by + 64'sd536870912) >>> 30);
            bz_reg <= 34'((bz + 64'sd536870912) >>> 30);
            ax_reg <= c0c1_reg;
            ay_reg <= c1s0_reg;
            az_reg <= s1k_reg;
        end
    end

    // stage 3: link scaling
    logic signed [50:0] lx_reg, ly_reg, lz_reg;
    logic signed [50:0] mx_reg, my_reg, mz_reg;
    logic signed [16:0] l1, l2;

    assign l1 = signed'({1'b0, upper_len});
    assign l2 = signed'({1'b0, lower_len});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg <= 51'(l1) * 51'(ax_reg);
            ly_reg <= 51'(l1) * 51'(ay_reg);
            lz_reg <= 51'(l1) * 51'(az_reg);
            mx_reg <= 51'(l2) * 51'(bx_reg);
            my_reg <= 51'(l2) * 51'(by_reg);
            mz_reg <= 51'(l2) * 51'(bz_reg);
        end
    end

    function automatic logic signed [19:0] fin(input logic signed [51:0] t,
                                              output logic clip);
        logic signed [51:0] r;
        r    = (t + 52'sd536870912) >>> 30;
        clip = 1'b0;
        if (r > 52'sd262143)
        begin
            r    = 52'sd262143;
            clip = 1'b1;
        end
        else if (r < -52'sd262143)
        begin
            r    = -52'sd262143;
            clip = 1'b1;
        end
        return {1'b0, r[18:0]};
    endfunction

    // stage 4: round and clip
    logic signed [19:0] rx, ry, rz;
    logic               kx, ky, kz;
    logic signed [18:0] x_reg, y_reg, z_reg;
    logic               sat_reg;

    always_comb
    begin
        rx = fin(52'(lx_reg) + 52'(mx_reg), kx);
        ry = fin(52'(ly_reg) + 52'(my_reg), ky);
        rz = fin(52'(lz_reg) + 52'(mz_reg), kz);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= rx[18:0];
            y_reg   <= ry[18:0];
            z_reg   <= rz[18:0];
            sat_reg <= kx | ky | kz;
        end
    end

    assign x_pos = x_reg;
    assign y_pos = y_reg;
    assign z_pos = z_reg;
    assign sat   = sat_reg;

endmodule
`default_nettype wire

/* src/arm_forward_kinematics.sv */
// Pipeline: CORDIC lanes (CORDIC_STAGES rotation stages, capped at 24) then the merge
// stages; a result also waits in the output register until ready is seen.
// Throughput: one pose per cycle; the whole pipeline advances as one and
// holds only when the output register is full and not taken.
// Reset: link lengths clear to zero and all pipeline valid bits clear.
// ----------------------------------------------------------------------------
// arm_forward_kinematics - two-link four-joint arm end-effector position
// Four CORDIC lanes, one per joint, feed a product merge pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module arm_forward_kinematics
    import afk_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_we,
    input  wire               cfg_index,
    input  wire        [15:0] cfg_data,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire               arm_id,
    input  wire signed [15:0] joint0_angle,
    input  wire signed [15:0] joint1_angle,
    input  wire signed [15:0] joint2_angle,
    input  wire signed [15:0] joint3_angle,
    output logic              out_valid,
    input  wire               out_ready,
    output logic              arm_tag,
    output logic signed [18:0] x_pos,
    output logic signed [18:0] y_pos,
    output logic signed [18:0] z_pos,
    output logic              saturated
);

    localparam int NS    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int DEPTH = NS + 6;

    logic [15:0] upper_reg, lower_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            lower_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UPPER: upper_reg <= cfg_data;
                CFG_LOWER: lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline stalls as a whole when the last stage holds an untaken result.
    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] tag_reg;

    assign en       = !(vld_reg[DEPTH-1] && !out_ready);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            tag_reg <= {tag_reg[DEPTH-2:0], arm_id};
    end

    sincos_t sc0, sc1, sc2, sc3;

    afk_cordic #(.STAGES(CORDIC_STAGES)) u_lane0
        (.clk(clk), .en(en), .angle(joint0_angle), .result(sc0));
    afk_cordic #(.STAGES(CORDIC_STAGES)) u_lane1
        (.clk(clk), .en(en), .angle(joint1_angle), .result(sc1));
    afk_cordic #(.STAGES(CORDIC_STAGES)) u_lane2
        (.clk(clk), .en(en), .angle(joint2_angle), .result(sc2));
    afk_cordic #(.STAGES(CORDIC_STAGES)) u_lane3
        (.clk(clk), .en(en), .angle(joint3_angle), .result(sc3));

    afk_merge u_merge (
        .clk      (clk),
        .en       (en),
        .j0       (sc0),
        .j1       (sc1),
        .j2       (sc2),
        .j3       (sc3),
        .upper_len(upper_reg),
        .lower_len(lower_reg),
        .x_pos    (x_pos),
        .y_pos    (y_pos),
        .z_pos    (z_pos),
        .sat      (saturated)
    );

    assign out_valid = vld_reg[DEPTH-1];
    assign arm_tag   = tag_reg[DEPTH-1];

endmodule
`default_nettype wire

/* src/afk_checker.sv */
// ----------------------------------------------------------------------------
// afk_checker - port-level checks for arm_forward_kinematics
// Handshake and result range properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module afk_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               in_ready,
    input wire               out_valid,
    input wire               out_ready,
    input wire signed [18:0] x_pos,
    input wire signed [18:0] y_pos,
    input wire signed [18:0] z_pos
);

    // a result held back must stall the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transfer");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (x_pos != -19'sd262144 && y_pos != -19'sd262144
                       && z_pos != -19'sd262144))
        else $error("coordinate outside saturation range");

endmodule

bind arm_forward_kinematics afk_checker u_afk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .x_pos    (x_pos),
    .y_pos    (y_pos),
    .z_pos    (z_pos)
);
`default_nettype wire
